// ===== hdl/signed_int_to_decimal_ascii_defines.svh =====
// Assertion macros used by the port-level checker of the integer to text converter.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SIDA_ASSERT_IMP(name, ck, rs, pre, post) \
  name: assert property (@(posedge ck) disable iff (rs) (pre) |-> (post)) \
    else $error("sida check failed");

// Next-cycle implication, disabled during reset.
`define SIDA_ASSERT_NXT(name, ck, rs, pre, post) \
  name: assert property (@(posedge ck) disable iff (rs) (pre) |=> (post)) \
    else $error("sida check failed");

`endif

// ===== hdl/sida_pkg.sv =====
// Types and constants shared by the integer to decimal text converter.
package sida_pkg;

  // Magnitude bits folded into the BCD register per conversion cycle.
  localparam int DIGIT_STEP = 4;

  localparam logic [5:0] CHAR_ZERO  = 6'd48;
  localparam logic [5:0] CHAR_MINUS = 6'd45;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_LEN,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  typedef struct packed {
    logic load;
    logic conv;
    logic find_len;
    logic emit_sign;
    logic emit_digit;
  } dp_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic negative;
    logic last_digit;
    logic out_free;
  } dp_status_t;

endpackage

// ===== hdl/sida_ctrl.sv =====
// Sequencing state machine of the integer to decimal text converter.
module sida_ctrl
  import sida_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // No word is taken while reset is held.
        s_tready = !rst;
        if (s_tvalid && !rst) begin
          cmd.load   = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.conv = 1'b1;
        if (status.conv_done) begin
          state_next = ST_LEN;
        end
      end
      ST_LEN: begin
        cmd.find_len = 1'b1;
        state_next   = status.negative ? ST_SIGN : ST_DIGIT;
      end
      ST_SIGN: begin
        if (status.out_free) begin
          cmd.emit_sign = 1'b1;
          state_next    = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (status.out_free) begin
          cmd.emit_digit = 1'b1;
          if (status.last_digit) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/sida_dp.sv =====
// Datapath: magnitude, shift-add-3 BCD converter, digit pointer and output register.
module sida_dp
  import sida_pkg::*;
#(
  parameter int VALUE_BITS = 32,
  parameter int IN_W       = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [IN_W-1:0]   s_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,
  output logic              m_tlast,
  input  dp_cmd_t           cmd,
  output dp_status_t        status
);

  localparam int MAG_W  = ((VALUE_BITS + DIGIT_STEP - 1) / DIGIT_STEP) * DIGIT_STEP;
  localparam int STEPS  = MAG_W / DIGIT_STEP;
  localparam int STEP_W = $clog2(STEPS);
  // Decimal digits of 2^VALUE_BITS - 1 (1233/4096 approximates log10 of 2).
  localparam int ND     = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int IDX_W  = $clog2(ND);

  logic [MAG_W-1:0]      mag;
  logic [4*ND-1:0]       bcd;
  logic [STEP_W-1:0]     step;
  logic                  negative;
  logic [IDX_W-1:0]      idx;
  logic [5:0]            ascii;

  logic [VALUE_BITS-1:0] v_in;
  logic [VALUE_BITS-1:0] v_abs;
  logic [MAG_W-1:0]      mag_next;
  logic [4*ND-1:0]       bcd_next;
  logic [IDX_W-1:0]      top_idx;
  logic [3:0]            digit;

  assign v_in  = s_tdata[VALUE_BITS-1:0];
  // The most negative value wraps to itself, which read unsigned is its magnitude.
  assign v_abs = v_in[VALUE_BITS-1] ? (~v_in + 1'b1) : v_in;

  always_comb begin
    bcd_next = bcd;
    mag_next = mag;
    for (int k = 0; k < DIGIT_STEP; k++) begin
      for (int d = 0; d < ND; d++) begin
        if (bcd_next[4*d +: 4] >= 4'd5) begin
          bcd_next[4*d +: 4] = bcd_next[4*d +: 4] + 4'd3;
        end
      end
      bcd_next = {bcd_next[4*ND-2:0], mag_next[MAG_W-1]};
      mag_next = {mag_next[MAG_W-2:0], 1'b0};
    end
  end

  // Highest nonzero digit; zero keeps a single digit.
  always_comb begin
    top_idx = '0;
    for (int d = 0; d < ND; d++) begin
      if (bcd[4*d +: 4] != 4'd0) begin
        top_idx = IDX_W'(d);
      end
    end
  end

  assign digit = bcd[4*idx +: 4];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag      <= MAG_W'(v_abs);
      bcd      <= '0;
      step     <= '0;
      negative <= v_in[VALUE_BITS-1];
    end else if (cmd.conv) begin
      mag  <= mag_next;
      bcd  <= bcd_next;
      step <= step + 1'b1;
    end
    if (cmd.find_len) begin
      idx <= top_idx;
    end else if (cmd.emit_digit) begin
      idx <= idx - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      ascii   <= CHAR_MINUS;
      m_tlast <= 1'b0;
    end else if (cmd.emit_digit) begin
      ascii   <= CHAR_ZERO + {2'b00, digit};
      m_tlast <= (idx == '0);
    end
  end

  assign m_tdata = {2'b00, ascii};

  assign status.conv_done  = (step == STEP_W'(STEPS - 1));
  assign status.negative   = negative;
  assign status.last_digit = (idx == '0);
  assign status.out_free   = !m_tvalid || m_tready;

endmodule

// ===== hdl/signed_int_to_decimal_ascii.sv =====
// Per word: accept, BCD conversion (4 bits per cycle through the shift-add-3
// converter), finding the leading digit, then one character per cycle while the
// sink is ready: at 32 bits an item has 1 to 11 characters. The next word is
// taken while the last character still waits in the output register.
// Synchronous active-high rst returns the sequencer to idle and drops m_tvalid.
module signed_int_to_decimal_ascii
  import sida_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((VALUE_BITS + 7) / 8)*8-1:0] s_tdata,  // value
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [7:0]                          m_tdata,  // ascii_char, zero pad
  output logic                                m_tlast   // last_char
);

  localparam int IN_W = ((VALUE_BITS + 7) / 8) * 8;

  dp_cmd_t    cmd;
  dp_status_t status;

  sida_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sida_dp #(
    .VALUE_BITS (VALUE_BITS),
    .IN_W       (IN_W)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cmd      (cmd),
    .status   (status)
  );

endmodule

// ===== hdl/sida_checker.sv =====
// Port-level checks of the integer to decimal text converter, bound to the top level.
`include "signed_int_to_decimal_ascii_defines.svh"

module sida_checker
  import sida_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic [((VALUE_BITS + 7) / 8)*8-1:0] s_tdata,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [7:0]                          m_tdata,
  input logic                                m_tlast
);

  logic is_minus;
  logic is_digit;

  assign is_minus = (m_tdata == {2'b00, CHAR_MINUS});
  assign is_digit = (m_tdata >= {2'b00, CHAR_ZERO}) && (m_tdata <= {2'b00, CHAR_ZERO + 6'd9});

  // A stalled word keeps its character and flag.
  `SIDA_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // Only a minus sign or a decimal digit ever appears.
  `SIDA_ASSERT_IMP(a_char_range, clk, rst, m_tvalid, is_minus || is_digit)

  // The text never ends on its sign.
  `SIDA_ASSERT_IMP(a_minus_not_last, clk, rst, m_tvalid && is_minus, !m_tlast)

  // Conversion of an accepted word always takes the cycle after it.
  `SIDA_ASSERT_NXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)

endmodule

bind signed_int_to_decimal_ascii sida_checker #(.VALUE_BITS(VALUE_BITS)) u_sida_checker (.*);

// ===== tb/signed_int_to_decimal_ascii_checker.sv =====
// Checker for the integer to decimal text converter: predicts the characters of each word and compares.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_checker
  import sida_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  input  logic                                s_tready,
  input  logic [((VALUE_BITS + 7) / 8)*8-1:0] s_tdata,  // value
  input  logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic [7:0]                          m_tdata,  // ascii_char, zero pad
  input  logic                                m_tlast,  // last_char
  output int                                  errors,
  output int                                  pending
);

  typedef struct packed {
    logic [5:0] ascii_char;
    logic       last_char;
  } text_char_t;

  text_char_t text_chars[$];

  // Appends the decimal text of one word, sign first, then digits from the most significant.
  function automatic void queue_decimal_text(input logic [VALUE_BITS-1:0] value);
    logic [VALUE_BITS-1:0] magnitude;
    logic [3:0]            digits[20];
    int                    count;
    text_char_t            item;
    // The most negative value negates to itself, which read as unsigned is its magnitude.
    magnitude = value[VALUE_BITS-1] ? -value : value;
    count = 0;
    do begin
      digits[count] = 4'(magnitude % 10);
      count++;
      magnitude = magnitude / 10;
    end while (magnitude != 0 && count < 20);
    if (value[VALUE_BITS-1]) begin
      item.ascii_char = CHAR_MINUS;
      item.last_char = 1'b0;
      text_chars.push_back(item);
    end
    for (int i = count - 1; i >= 0; i--) begin
      item.ascii_char = CHAR_ZERO + digits[i];
      item.last_char = (i == 0);
      text_chars.push_back(item);
    end
  endfunction

  always @(posedge clk) begin
    text_char_t want;
    if (rst) begin
      text_chars.delete();
    end else begin
      // Characters of the word accepted at this edge cannot leave at the same edge.
      if (m_tvalid && m_tready) begin
        if (text_chars.size() == 0) begin
          errors++;
          $display("%0t: unexpected character, expected none, got ascii_char %0d last_char %0b",
                   $time, m_tdata[5:0], m_tlast);
        end else begin
          want = text_chars.pop_front();
          if (m_tdata[5:0] !== want.ascii_char) begin
            errors++;
            $display("%0t: ascii_char mismatch, expected %0d, got %0d",
                     $time, want.ascii_char, m_tdata[5:0]);
          end
          if (m_tlast !== want.last_char) begin
            errors++;
            $display("%0t: last_char mismatch, expected %0b, got %0b",
                     $time, want.last_char, m_tlast);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        queue_decimal_text(s_tdata[VALUE_BITS-1:0]);
      end
    end
    pending <= text_chars.size();
  end

endmodule

// ===== tb/signed_int_to_decimal_ascii_test.sv =====
// Stimulus and verdict for the integer to decimal text converter.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_test;

  localparam int VALUE_BITS = 32;
  localparam int HOLD_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  int mismatches;
  int chars_pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;

  int directed_values[] = '{
    0, 1, -1, 9, -9, 10, -10, 99, 100, 7,
    32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001,
    1000000000, -1000000000, 999999999, -999999999,
    123456789, -123456789, 32'h5555_5555, 32'haaaa_aaaa, 1000000
  };

  always #10 clk = ~clk;

  signed_int_to_decimal_ascii #(
    .VALUE_BITS(VALUE_BITS)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  signed_int_to_decimal_ascii_checker #(
    .VALUE_BITS(VALUE_BITS)
  ) i_checker (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .errors  (mismatches),
    .pending (chars_pending)
  );

  // Sink side: a requested hold keeps tready low for a long stretch, else random stalls.
  always @(posedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic send_word(input logic [31:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata <= $urandom;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= value;
    do @(posedge clk); while (!s_tready);
  endtask

  // The checker's count is registered, so the task always waits on the clock before it tests the count.
  task automatic drain_text();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (chars_pending != 0);
  endtask

  function automatic logic [31:0] random_word();
    int          pick;
    int          digits;
    logic [31:0] magnitude;
    pick = $urandom_range(9);
    if (pick < 4) begin
      return $urandom;
    end else if (pick < 7) begin
      digits = $urandom_range(9, 1);
      magnitude = $urandom_range(10 ** digits - 1, (digits == 1) ? 0 : 10 ** (digits - 1));
    end else if (pick < 9) begin
      // Powers of ten and the all-nines value just below them.
      magnitude = (10 ** $urandom_range(9)) - $urandom_range(1);
    end else begin
      return $urandom_range(1) ? 32'h8000_0000 + $urandom_range(3)
                               : 32'h7fff_ffff - $urandom_range(3);
    end
    return $urandom_range(1) ? -magnitude : magnitude;
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 10;
    recv_idle_pct <= 71;
    foreach (directed_values[i]) send_word(directed_values[i]);
    drain_text();
    for (int n = 0; n < 110; n++) send_word(random_word());
    drain_text();

    send_idle_pct = 71;
    recv_idle_pct <= 10;
    for (int n = 0; n < 110; n++) send_word(random_word());
    drain_text();

    // No idling; the sink first holds off so the converter backs up into its input.
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_requests <= hold_requests + 1;
    for (int n = 0; n < 100; n++) send_word(random_word());
    drain_text();

    repeat (40) @(posedge clk);
    if (mismatches == 0 && chars_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/sida_pkg.sv
hdl/sida_ctrl.sv
hdl/sida_dp.sv
hdl/signed_int_to_decimal_ascii.sv
hdl/sida_checker.sv
tb/signed_int_to_decimal_ascii_checker.sv
tb/signed_int_to_decimal_ascii_test.sv
